// ----- hw/rtl/fts_pkg.sv -----
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, codes and types of the fair thread-priority scheduler.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int MASK_W          = 16;
    localparam int THREAD_W        = 4;
    localparam int NUM_THREADS_DEF = 16;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DONE  = 3'b100
    } t_state;

    // Control for one pass of the row unit.
    typedef struct packed {
        logic upd;     // update request with a thread inside the table
        logic is_t;    // this row belongs to the taken thread
        logic exists;  // this row's thread has yielded at least once
        logic yield;   // the taken step was a yield
    } t_row_ctl;

endpackage

// ----- hw/rtl/fts_row_unit.sv -----
// ----------------------------------------------------------------------------
// fts_row_unit
// Next value of one thread's row: priority row and its E, D and S sets.
// ----------------------------------------------------------------------------
module fts_row_unit
    import fts_pkg::*;
#(
    parameter int ROW_W = MASK_W
) (
    input  t_row_ctl           i_ctl,
    input  logic [ROW_W-1:0]   i_tbit,
    input  logic [ROW_W-1:0]   i_prev,
    input  logic [ROW_W-1:0]   i_curr,
    input  logic [ROW_W-1:0]   i_p,
    input  logic [ROW_W-1:0]   i_e,
    input  logic [ROW_W-1:0]   i_d,
    input  logic [ROW_W-1:0]   i_s,
    output logic [ROW_W-1:0]   o_p,
    output logic [ROW_W-1:0]   o_e,
    output logic [ROW_W-1:0]   o_d,
    output logic [ROW_W-1:0]   o_s
);

    logic [ROW_W-1:0] p1;
    logic [ROW_W-1:0] e1;
    logic [ROW_W-1:0] d1;
    logic [ROW_W-1:0] s1;

    always_comb begin
        p1 = i_p & ~i_tbit;
        e1 = i_ctl.exists ? (i_e & i_curr) : i_e;
        s1 = i_ctl.exists ? (i_s | i_tbit) : i_s;
        d1 = (i_ctl.is_t && i_ctl.exists) ? (i_d | (i_prev & ~i_curr)) : i_d;

        if (!i_ctl.upd) begin
            o_p = i_p;
            o_e = i_e;
            o_d = i_d;
            o_s = i_s;
        end else if (i_ctl.is_t && i_ctl.yield) begin
            // The yielding thread now waits for everything it may have starved.
            o_p = p1 | ((e1 | d1) & ~s1);
            o_e = i_curr;
            o_d = '0;
            o_s = '0;
        end else begin
            o_p = p1;
            o_e = e1;
            o_d = d1;
            o_s = s1;
        end
    end

endmodule

// ----- hw/rtl/fair_thread_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// fair_thread_priority_scheduler
// Keeps the thread priority relation of a fair scheduler and answers queries.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// request  in         i_valid / o_stall   i_mode, i_thread, i_was_yield,
//                                         i_prev_enabled, i_curr_enabled
// result   out        o_valid / i_stall   o_fairly_enabled, o_fair_mask
//
// Every request sweeps the thread table one row per cycle through the shared
// row unit. The result is valid once every row has been read from the table,
// whose read data is registered, and written back through the row unit.
// The block takes one request at a time; o_stall stays high until the result
// is taken. Reset is synchronous and leaves the table reading as all zero.
// ----------------------------------------------------------------------------
module fair_thread_priority_scheduler
    import fts_pkg::*;
#(
    parameter int NUM_THREADS = NUM_THREADS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_mode,
    input  logic [THREAD_W-1:0] i_thread,
    input  logic                i_was_yield,
    input  logic [MASK_W-1:0]   i_prev_enabled,
    input  logic [MASK_W-1:0]   i_curr_enabled,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_fairly_enabled,
    output logic [MASK_W-1:0]   o_fair_mask
);

    // Masks are 16 bits wide and thread numbers 4 bits, so no more rows can be used.
    localparam int ROW_W = (NUM_THREADS < MASK_W) ? NUM_THREADS : MASK_W;
    localparam int IDX_W = (ROW_W > 1) ? $clog2(ROW_W) : 1;
    localparam int ENT_W = 4 * ROW_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROW_W - 1);

    t_state               r_state;
    t_state               n_state;
    logic                 r_mode;
    logic [THREAD_W-1:0]  r_thr;
    logic                 r_thr_ok;
    logic                 r_yield;
    logic [ROW_W-1:0]     r_prev;
    logic [ROW_W-1:0]     r_curr;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_go;
    logic [IDX_W-1:0]     r_wr_idx;
    logic                 r_wr_go;
    logic [ENT_W-1:0]     r_mem [ROW_W];
    logic [ENT_W-1:0]     r_rd_data;
    logic                 r_rd_vld;
    logic [ROW_W-1:0]     r_vld;
    logic [ROW_W-1:0]     r_exists;
    logic                 r_fe;
    logic [ROW_W-1:0]     r_fair;

    logic                 accept;
    logic                 thr_in_range;
    logic [IDX_W-1:0]     thr_idx;
    logic [ROW_W-1:0]     tbit;
    logic                 is_t;
    logic                 do_write;
    t_row_ctl             row_ctl;
    logic [ROW_W-1:0]     rd_p;
    logic [ROW_W-1:0]     rd_e;
    logic [ROW_W-1:0]     rd_d;
    logic [ROW_W-1:0]     rd_s;
    logic [ROW_W-1:0]     nx_p;
    logic [ROW_W-1:0]     nx_e;
    logic [ROW_W-1:0]     nx_d;
    logic [ROW_W-1:0]     nx_s;

    assign o_stall          = (r_state != ST_IDLE);
    assign accept           = i_valid && !o_stall;
    assign o_valid          = (r_state == ST_DONE);
    assign o_fairly_enabled = r_fe;
    assign o_fair_mask      = MASK_W'(r_fair);

    assign thr_in_range = ({1'b0, i_thread} < (THREAD_W + 1)'(ROW_W));
    assign thr_idx      = r_thr[IDX_W-1:0];
    assign tbit         = ROW_W'(1) << thr_idx;
    assign is_t         = (r_wr_idx == thr_idx);

    // A row never written since reset reads as all zero.
    assign rd_p = r_rd_vld ? r_rd_data[4*ROW_W-1 -: ROW_W] : '0;
    assign rd_e = r_rd_vld ? r_rd_data[3*ROW_W-1 -: ROW_W] : '0;
    assign rd_d = r_rd_vld ? r_rd_data[2*ROW_W-1 -: ROW_W] : '0;
    assign rd_s = r_rd_vld ? r_rd_data[ROW_W-1 -: ROW_W]   : '0;

    assign row_ctl.upd    = (r_mode == MODE_UPDATE) && r_thr_ok;
    assign row_ctl.is_t   = is_t;
    assign row_ctl.exists = r_exists[r_wr_idx];
    assign row_ctl.yield  = r_yield;

    assign do_write = r_wr_go && row_ctl.upd;

    fts_row_unit #(
        .ROW_W (ROW_W)
    ) u_row (
        .i_ctl  (row_ctl),
        .i_tbit (tbit),
        .i_prev (r_prev),
        .i_curr (r_curr),
        .i_p    (rd_p),
        .i_e    (rd_e),
        .i_d    (rd_d),
        .i_s    (rd_s),
        .o_p    (nx_p),
        .o_e    (nx_e),
        .o_d    (nx_d),
        .o_s    (nx_s)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_wr_go && (r_wr_idx == LAST_IDX)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Row table: one read and one write port, read data registered.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_rd_idx];
        if (do_write) begin
            r_mem[r_wr_idx] <= {nx_p, nx_e, nx_d, nx_s};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_go  <= 1'b0;
            r_wr_go  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_vld    <= '0;
            r_exists <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_vld[r_rd_idx];
            r_wr_go  <= r_rd_go;
            if (accept) begin
                r_rd_go <= 1'b1;
            end else if (r_rd_go && (r_rd_idx == LAST_IDX)) begin
                r_rd_go <= 1'b0;
            end
            if (do_write) begin
                r_vld[r_wr_idx] <= 1'b1;
                if (is_t && r_yield) begin
                    r_exists[r_wr_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_thr    <= i_thread;
            r_thr_ok <= thr_in_range;
            r_yield  <= i_was_yield;
            r_prev   <= i_prev_enabled[ROW_W-1:0];
            r_curr   <= i_curr_enabled[ROW_W-1:0];
            r_rd_idx <= '0;
            r_fe     <= (i_mode == MODE_QUERY);
            r_fair   <= '0;
        end else begin
            if (r_rd_go && (r_rd_idx != LAST_IDX)) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_wr_go) begin
                r_fair[r_wr_idx] <= r_curr[r_wr_idx] && ((nx_p & r_curr) == '0);
                if ((r_mode == MODE_QUERY) && r_thr_ok && is_t) begin
                    r_fe <= ((rd_p & r_curr) == '0);
                end
            end
        end
        r_wr_idx <= r_rd_idx;
    end

endmodule

// ----- hw/rtl/fts_checker.sv -----
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks of the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
module fts_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall
);

    // A pending result holds until it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped while stalled");

    // No new request is taken while a result is pending.
    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request channel open while result pending");

    // An accepted request closes the request channel.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request channel still open after accept");

    // An accepted request is not followed at once by a result; the table sweep comes first.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !o_valid ##1 !o_valid)
        else $error("result appeared before the sweep finished");

endmodule

bind fair_thread_priority_scheduler fts_checker u_fts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall)
);

// ----- test/tb_fair_thread_priority_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_fair_thread_priority_scheduler
// Checks the fair thread-priority scheduler against a cycle-free predictor.
// A short directed run builds and clears known priorities; random scheduling
// sequences with queries, plus raw noise, follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_fair_thread_priority_scheduler;
    import fts_pkg::*;

    localparam int NTHR        = NUM_THREADS_DEF;
    localparam int RAND_ITEMS  = 1150;
    localparam int DRAIN       = 2 * (NTHR + 2);
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_FROM  = 6000;
    localparam int QUIET_TO    = 12000;
    localparam logic [MASK_W-1:0] THREAD_MASK =
        (NTHR >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << NTHR) - 1);

    typedef struct packed {
        logic                mode;
        logic [THREAD_W-1:0] thread;
        logic                was_yield;
        logic [MASK_W-1:0]   prev_en;
        logic [MASK_W-1:0]   curr_en;
    } t_sched_req;

    typedef struct packed {
        logic              fairly;
        logic [MASK_W-1:0] mask;
    } t_fair_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                i_mode         = MODE_UPDATE;
    logic [THREAD_W-1:0] i_thread       = '0;
    logic                i_was_yield    = 1'b0;
    logic [MASK_W-1:0]   i_prev_enabled = '0;
    logic [MASK_W-1:0]   i_curr_enabled = '0;
    logic                i_stall        = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                o_fairly_enabled;
    logic [MASK_W-1:0]   o_fair_mask;

    fair_thread_priority_scheduler #(
        .NUM_THREADS(NTHR)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_thread        (i_thread),
        .i_was_yield     (i_was_yield),
        .i_prev_enabled  (i_prev_enabled),
        .i_curr_enabled  (i_curr_enabled),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_fairly_enabled(o_fairly_enabled),
        .o_fair_mask     (o_fair_mask)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sched_req   request_q[$];
    t_fair_result expected_fairness[$];
    t_fair_result observed;
    int           errors      = 0;
    int           cycle_count = 0;
    logic         quiet;

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    // Predicted scheduler state: row u holds the threads that outrank u.
    logic [MASK_W-1:0] outranks    [NTHR] = '{default: '0};
    logic [MASK_W-1:0] en_since    [NTHR] = '{default: '0};
    logic [MASK_W-1:0] dis_since   [NTHR] = '{default: '0};
    logic [MASK_W-1:0] sched_since [NTHR] = '{default: '0};
    logic [NTHR-1:0]   has_yielded = '0;

    function automatic t_fair_result predict_scheduler_step(t_sched_req r);
        t_fair_result      res;
        logic [MASK_W-1:0] prev_m;
        logic [MASK_W-1:0] curr_m;
        int                t;
        prev_m     = r.prev_en & THREAD_MASK;
        curr_m     = r.curr_en & THREAD_MASK;
        t          = r.thread;
        res.fairly = 1'b0;
        if (r.mode == MODE_UPDATE) begin
            if (t < NTHR) begin
                for (int u = 0; u < NTHR; u++) begin
                    outranks[u][t] = 1'b0;
                end
                for (int u = 0; u < NTHR; u++) begin
                    if (has_yielded[u]) en_since[u] &= curr_m;
                end
                if (has_yielded[t]) dis_since[t] |= prev_m & ~curr_m;
                for (int u = 0; u < NTHR; u++) begin
                    if (has_yielded[u]) sched_since[u][t] = 1'b1;
                end
                if (r.was_yield) begin
                    outranks[t]   |= (en_since[t] | dis_since[t]) & ~sched_since[t];
                    en_since[t]    = curr_m;
                    dis_since[t]   = '0;
                    sched_since[t] = '0;
                    has_yielded[t] = 1'b1;
                end
            end
        end else begin
            res.fairly = 1'b1;
            if (t < NTHR && (outranks[t] & curr_m) != '0) res.fairly = 1'b0;
        end
        res.mask = '0;
        for (int u = 0; u < NTHR; u++) begin
            if (curr_m[u] && (outranks[u] & curr_m) == '0) res.mask[u] = 1'b1;
        end
        return res;
    endfunction

    task automatic queue_request(input logic mode, input int thr, input logic yld,
                                 input logic [MASK_W-1:0] prev_m,
                                 input logic [MASK_W-1:0] curr_m);
        t_sched_req r;
        r.mode      = mode;
        r.thread    = THREAD_W'(thr);
        r.was_yield = yld;
        r.prev_en   = prev_m;
        r.curr_en   = curr_m;
        request_q   = {request_q, r};
    endtask

    function automatic int pick_enabled(logic [MASK_W-1:0] live);
        int idx;
        if ((live & THREAD_MASK) == '0) return $urandom_range(NTHR - 1);
        do begin
            idx = $urandom_range(NTHR - 1);
        end while (!live[idx]);
        return idx;
    endfunction

    // Request driver: holds a stalled request, otherwise loads the next one or idles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_fairness = {expected_fairness, predict_scheduler_step(
                    t_sched_req'{i_mode, i_thread, i_was_yield,
                                 i_prev_enabled, i_curr_enabled})};
            end
            if (!(i_valid && o_stall)) begin
                if (request_q.size() != 0 && (quiet || $urandom_range(99) >= 30)) begin
                    {i_mode, i_thread, i_was_yield, i_prev_enabled, i_curr_enabled}
                        <= request_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_fairness.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result: fairly_enabled=%0b fair_mask=%h",
                                 o_fairly_enabled, o_fair_mask);
                    errors++;
                end else begin
                    observed = expected_fairness.pop_front();
                    if (o_fairly_enabled !== observed.fairly ||
                        o_fair_mask !== observed.mask) begin
                        if (errors < 10)
                            $display("mismatch: fairly_enabled exp %0b got %0b, %s %h got %h",
                                     observed.fairly, o_fairly_enabled, "fair_mask exp",
                                     observed.mask, o_fair_mask);
                        errors++;
                    end
                end
            end
            i_stall <= !quiet && ($urandom_range(99) < 30);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [MASK_W-1:0] live;
        logic [MASK_W-1:0] nxt;
        int                roll;
        int                flips;

        // Thread 0 yields three times so that the threads that stayed enabled and
        // were never scheduled come to outrank it; runs of other threads then
        // clear their columns again.
        queue_request(MODE_QUERY,   0, 1'b0, 16'h0000, 16'h0000);
        queue_request(MODE_QUERY,  15, 1'b1, 16'hFFFF, 16'hFFFF);
        queue_request(MODE_UPDATE,  0, 1'b0, 16'h0000, 16'hFFFF);
        queue_request(MODE_UPDATE,  0, 1'b1, 16'hFFFF, 16'hFFFF);
        queue_request(MODE_UPDATE,  1, 1'b0, 16'hFFFF, 16'h7FFF);
        queue_request(MODE_UPDATE,  3, 1'b0, 16'h7FFF, 16'h3FFF);
        queue_request(MODE_UPDATE,  0, 1'b1, 16'h3FFF, 16'h3FFF);
        queue_request(MODE_QUERY,   0, 1'b0, 16'h0000, 16'hFFFF);
        queue_request(MODE_QUERY,   0, 1'b0, 16'h0000, 16'h0003);
        queue_request(MODE_UPDATE,  0, 1'b0, 16'hFFFF, 16'h0FFF);
        queue_request(MODE_UPDATE,  2, 1'b0, 16'h0FFF, 16'h0FFF);
        queue_request(MODE_UPDATE,  0, 1'b1, 16'h0FFF, 16'hFFFF);
        queue_request(MODE_QUERY,   0, 1'b1, 16'hFFFF, 16'h0004);
        queue_request(MODE_QUERY,   0, 1'b0, 16'h0000, 16'h8000);
        queue_request(MODE_UPDATE, 15, 1'b1, 16'hFFFF, 16'h0000);
        queue_request(MODE_UPDATE, 15, 1'b1, 16'h0000, 16'hFFFF);
        queue_request(MODE_QUERY,  15, 1'b0, 16'h0000, 16'hFFFF);
        queue_request(MODE_UPDATE,  7, 1'b0, 16'hFFFF, 16'h0000);
        queue_request(MODE_QUERY,   7, 1'b0, 16'hFFFF, 16'hFFFF);

        // Random scheduling runs: the taken thread is mostly an enabled one and
        // the enabled set drifts a few threads per step.
        live = MASK_W'($urandom);
        repeat (RAND_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                queue_request(1'($urandom), $urandom_range(NTHR - 1), 1'($urandom),
                              MASK_W'($urandom), MASK_W'($urandom));
            end else if (roll < 35) begin
                queue_request(MODE_QUERY,
                              ($urandom_range(3) != 0) ? pick_enabled(live)
                                                       : $urandom_range(NTHR - 1),
                              1'($urandom), MASK_W'($urandom), live);
            end else begin
                nxt   = live;
                flips = $urandom_range(2);
                repeat (flips) nxt[$urandom_range(NTHR - 1)] ^= 1'b1;
                queue_request(MODE_UPDATE, pick_enabled(live),
                              $urandom_range(99) < 30, live, nxt);
                live = nxt;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || i_valid || expected_fairness.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
